### design/stb_pkg.sv
`timescale 1ns / 1ps
// stb_pkg: widths, command codes and payload types for the soft timer bank
// no dependencies; imported by every other file of the block

package stb_pkg;

    localparam int TIMER_COUNT = 8;
    localparam int TIMER_IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int EVENT_W     = 8;

    localparam logic [30:0] UPTIME_WRAP = 31'h7FFF_FFFF;

    localparam logic [2:0] CMD_TICK        = 3'd0;
    localparam logic [2:0] CMD_START_ONCE  = 3'd1;
    localparam logic [2:0] CMD_START_AUTO  = 3'd2;
    localparam logic [2:0] CMD_START_CB    = 3'd3;
    localparam logic [2:0] CMD_STOP        = 3'd4;
    localparam logic [2:0] CMD_CHECK       = 3'd5;
    localparam logic [2:0] CMD_CLEAR_FREE  = 3'd6;
    localparam logic [2:0] CMD_START_DELAY = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  timer_id;
        logic [15:0] period;
        logic [31:0] delay_length;
    } t_in_item;

    typedef struct packed {
        logic         check_hit;
        logic [7:0]   callback_events;
        logic         bad_id;
        logic         delay_done;
        logic [30:0]  uptime;
        logic [31:0]  free_run_time;
    } t_out_item;

    typedef struct packed {
        logic [15:0] remaining;
        logic [15:0] reload;
        logic        auto_reload;
        logic        callback_en;
    } t_timer_state;

    typedef struct packed {
        logic [15:0] remaining;
        logic        expire;
        logic        event_hit;
    } t_timer_next;

endpackage

### design/stb_if.sv
`timescale 1ns / 1ps
// stb_in_if, stb_out_if: valid/ready channels for commands and results
// depends on stb_pkg for the payload types

interface stb_in_if;
    logic              valid;
    logic              ready;
    stb_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface stb_out_if;
    logic               valid;
    logic               ready;
    stb_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/stb_timer_step.sv
`timescale 1ns / 1ps
// stb_timer_step: shared decrement, zero test and reload unit for one timer
// depends on stb_pkg for the timer state types

module stb_timer_step (
    input  stb_pkg::t_timer_state i_state,
    output stb_pkg::t_timer_next  o_next
);
    import stb_pkg::*;

    logic [15:0] dec;

    assign dec = i_state.remaining - 16'd1;

    always_comb begin
        o_next.remaining = i_state.remaining;
        o_next.expire    = 1'b0;
        o_next.event_hit = 1'b0;
        if (i_state.remaining != 16'd0) begin
            o_next.remaining = dec;
            if (dec == 16'd0) begin
                o_next.expire    = 1'b1;
                o_next.event_hit = i_state.callback_en;
                if (i_state.auto_reload) begin
                    o_next.remaining = i_state.reload;
                end
            end
        end
    end

endmodule

### design/soft_timer_bank.sv
`timescale 1ns / 1ps
// Soft timer bank: TIMER_COUNT 16-bit down-counting timers with delay, uptime
// and free-running counters. A tick command steps the timers one per cycle
// through the single shared decrement unit, then loads the result; every
// other command goes straight to the result load. Ready comes back in the
// idle state that follows the result load. Commands are taken one at a time
// and ready stays low until the result has been loaded into the output
// register, which also waits for the previous result to be taken. Depends
// on stb_pkg, stb_if and stb_timer_step.

module soft_timer_bank (
    input  logic           i_clk,
    input  logic           i_rst_n,
    stb_in_if.sink         i_in,
    stb_out_if.source      o_out
);
    import stb_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TICK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam logic [TIMER_IDX_W-1:0] LAST_IDX = TIMER_IDX_W'(TIMER_COUNT - 1);
    localparam logic [4:0]             COUNT_5  = 5'(TIMER_COUNT);

    logic [1:0]             r_state, n_state;
    logic [TIMER_IDX_W-1:0] r_idx, n_idx;

    logic [15:0] r_rem    [TIMER_COUNT];
    logic [15:0] n_rem    [TIMER_COUNT];
    logic [15:0] r_reload [TIMER_COUNT];
    logic [15:0] n_reload [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] r_exp, n_exp;
    logic [TIMER_COUNT-1:0] r_auto, n_auto;
    logic [TIMER_COUNT-1:0] r_cb, n_cb;

    logic [31:0]        r_delay, n_delay;
    logic               r_delay_flag, n_delay_flag;
    logic [30:0]        r_uptime, n_uptime;
    logic [31:0]        r_free, n_free;
    logic               r_hit, n_hit;
    logic               r_bad, n_bad;
    logic [EVENT_W-1:0] r_events, n_events;

    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    t_timer_state           step_in;
    t_timer_next            step_out;
    logic [TIMER_IDX_W-1:0] sel;
    logic                   id_ok;
    logic [30:0]            up_inc;
    logic [4:0]             idx_ext;

    assign sel     = i_in.data.timer_id[TIMER_IDX_W-1:0];
    assign id_ok   = {1'b0, i_in.data.timer_id} < COUNT_5;
    assign up_inc  = r_uptime + 31'd1;
    assign idx_ext = 5'(r_idx);

    assign step_in.remaining   = r_rem[r_idx];
    assign step_in.reload      = r_reload[r_idx];
    assign step_in.auto_reload = r_auto[r_idx];
    assign step_in.callback_en = r_cb[r_idx];

    stb_timer_step u_step (
        .i_state (step_in),
        .o_next  (step_out)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_rem        = r_rem;
        n_reload     = r_reload;
        n_exp        = r_exp;
        n_auto       = r_auto;
        n_cb         = r_cb;
        n_delay      = r_delay;
        n_delay_flag = r_delay_flag;
        n_uptime     = r_uptime;
        n_free       = r_free;
        n_hit        = r_hit;
        n_bad        = r_bad;
        n_events     = r_events;
        n_out        = r_out;
        n_out_valid  = r_out_valid;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_hit    = 1'b0;
                    n_bad    = 1'b0;
                    n_events = '0;
                    n_state  = S_FIN;
                    if (i_in.data.cmd inside {[CMD_START_ONCE:CMD_CHECK]} && !id_ok) begin
                        n_bad = 1'b1;
                    end else begin
                        case (i_in.data.cmd)
                            CMD_TICK: begin
                                if (r_delay != 32'd0) begin
                                    n_delay = r_delay - 32'd1;
                                    if (r_delay == 32'd1) begin
                                        n_delay_flag = 1'b1;
                                    end
                                end
                                n_uptime = (up_inc == UPTIME_WRAP) ? 31'd0 : up_inc;
                                n_free   = r_free + 32'd1;
                                n_idx    = '0;
                                n_state  = S_TICK;
                            end
                            CMD_START_ONCE, CMD_START_AUTO, CMD_START_CB: begin
                                n_rem[sel]    = i_in.data.period;
                                n_reload[sel] = i_in.data.period;
                                n_exp[sel]    = 1'b0;
                                n_auto[sel]   = (i_in.data.cmd != CMD_START_ONCE);
                                if (i_in.data.cmd == CMD_START_CB) begin
                                    n_cb[sel] = 1'b1;
                                end
                            end
                            CMD_STOP: begin
                                n_rem[sel]  = 16'd0;
                                n_exp[sel]  = 1'b0;
                                n_auto[sel] = 1'b0;
                            end
                            CMD_CHECK: begin
                                n_hit      = r_exp[sel];
                                n_exp[sel] = 1'b0;
                            end
                            CMD_CLEAR_FREE: begin
                                n_free = 32'd0;
                            end
                            default: begin
                                if (i_in.data.delay_length != 32'd0) begin
                                    n_delay      = i_in.data.delay_length;
                                    n_delay_flag = 1'b0;
                                end
                            end
                        endcase
                    end
                end
            end
            S_TICK: begin
                n_rem[r_idx] = step_out.remaining;
                if (step_out.expire) begin
                    n_exp[r_idx] = 1'b1;
                end
                for (int b = 0; b < EVENT_W; b++) begin
                    if (step_out.event_hit && (idx_ext == 5'(b))) begin
                        n_events[b] = 1'b1;
                    end
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out.check_hit       = r_hit;
                    n_out.callback_events = r_events;
                    n_out.bad_id          = r_bad;
                    n_out.delay_done      = r_delay_flag;
                    n_out.uptime          = r_uptime;
                    n_out.free_run_time   = r_free;
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_exp        <= '0;
            r_auto       <= '0;
            r_cb         <= '0;
            r_delay      <= '0;
            r_delay_flag <= 1'b0;
            r_uptime     <= '0;
            r_free       <= '0;
            r_hit        <= 1'b0;
            r_bad        <= 1'b0;
            r_events     <= '0;
            r_out_valid  <= 1'b0;
            for (int t = 0; t < TIMER_COUNT; t++) begin
                r_rem[t]    <= '0;
                r_reload[t] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_rem        <= n_rem;
            r_reload     <= n_reload;
            r_exp        <= n_exp;
            r_auto       <= n_auto;
            r_cb         <= n_cb;
            r_delay      <= n_delay;
            r_delay_flag <= n_delay_flag;
            r_uptime     <= n_uptime;
            r_free       <= n_free;
            r_hit        <= n_hit;
            r_bad        <= n_bad;
            r_events     <= n_events;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

### design/stb_checker.sv
`timescale 1ns / 1ps
// stb_checker: port-level assertions for soft_timer_bank, with its bind
// depends on stb_pkg for the uptime wrap constant

module stb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_check_hit,
    input logic        i_bad_id,
    input logic [7:0]  i_events,
    input logic [30:0] i_uptime
);
    import stb_pkg::*;

    // one command at a time: no transfer in the cycle after one
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready high right after a transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped before transfer");

    a_hit_not_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_check_hit && i_bad_id))
        else $error("check hit reported on a bad id");

    a_events_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_events != 8'd0)) |-> (!i_check_hit && !i_bad_id))
        else $error("callback events on a non-tick result");

    a_uptime_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_uptime != UPTIME_WRAP))
        else $error("uptime reached its wrap value");

endmodule

bind soft_timer_bank stb_checker u_stb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_check_hit (o_out.data.check_hit),
    .i_bad_id    (o_out.data.bad_id),
    .i_events    (o_out.data.callback_events),
    .i_uptime    (o_out.data.uptime)
);
